// ===== sv/qbrle_pkg.sv =====
`default_nettype none

package qbrle_pkg;

   // field widths
   localparam int unsigned QualityWidth = 8;
   localparam int unsigned BinWidth     = 3;
   localparam int unsigned CountWidth   = 5;
   localparam int unsigned CodeWidth    = BinWidth + CountWidth;

   // bin thresholds, highest first
   localparam logic [QualityWidth-1:0] Bin7Floor = 8'd73;
   localparam logic [QualityWidth-1:0] Bin6Floor = 8'd68;
   localparam logic [QualityWidth-1:0] Bin5Floor = 8'd63;
   localparam logic [QualityWidth-1:0] Bin4Floor = 8'd58;
   localparam logic [QualityWidth-1:0] Bin3Floor = 8'd53;
   localparam logic [QualityWidth-1:0] Bin2Floor = 8'd43;
   localparam logic [QualityWidth-1:0] Bin1Floor = 8'd35;

   // length field of a full run of 32
   localparam logic [CountWidth-1:0] RunCountMax = 5'd31;

   // output queue geometry
   localparam int unsigned FifoDepth      = 4;
   localparam int unsigned FifoPtrWidth   = 2;
   localparam int unsigned FifoCountWidth = 3;

   typedef logic [BinWidth-1:0]   bin_type;
   typedef logic [CountWidth-1:0] run_count_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code;
      logic                 record_done;
      logic                 last_of_item;
   } rsp_beat_type;

   // map a raw quality byte to its bin
   function automatic bin_type bin_of(input logic [QualityWidth-1:0] q);
      bin_type b;
      priority if (q >= Bin7Floor) b = 3'd7;
      else if (q >= Bin6Floor)     b = 3'd6;
      else if (q >= Bin5Floor)     b = 3'd5;
      else if (q >= Bin4Floor)     b = 3'd4;
      else if (q >= Bin3Floor)     b = 3'd3;
      else if (q >= Bin2Floor)     b = 3'd2;
      else if (q >= Bin1Floor)     b = 3'd1;
      else                         b = 3'd0;
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== sv/qbrle_if.sv =====
`default_nettype none

// quality byte channel
interface qbrle_req_if;
   logic                                valid;
   logic                                ready;
   logic [qbrle_pkg::QualityWidth-1:0] quality;
   logic                                record_end;

   modport source (output valid, output quality, output record_end, input ready);
   modport sink   (input valid, input quality, input record_end, output ready);
endinterface

// run code channel
interface qbrle_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [qbrle_pkg::CodeWidth-1:0] code;
   logic                             record_done;
   logic                             last_of_item;

   modport source (output valid, output code, output record_done, output last_of_item,
                   input ready);
   modport sink   (input valid, input code, input record_done, input last_of_item,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/qbrle_beat_fifo.sv =====
`default_nettype none

module qbrle_beat_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  qbrle_pkg::rsp_beat_type [1:0] push_beat,
   output logic                    room,
   output logic                    out_valid,
   output qbrle_pkg::rsp_beat_type out_beat,
   input  logic                    out_ready
);
   import qbrle_pkg::*;

   rsp_beat_type                entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0]   count_ff, count_in;
   logic                        pop;
   logic [FifoPtrWidth-1:0]     wr_ptr_next;

   assign pop         = out_valid & out_ready;
   assign out_valid   = (count_ff != '0);
   assign out_beat    = entry_ff[rd_ptr_ff];
   // room for a pair of beats
   assign room        = (count_ff <= FifoCountWidth'(FifoDepth - 2));
   assign wr_ptr_next = wr_ptr_ff + FifoPtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrWidth'(push_count);
      rd_ptr_in = rd_ptr_ff + FifoPtrWidth'(pop);
      count_in  = count_ff + FifoCountWidth'(push_count) - FifoCountWidth'(pop);
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write up to two beats at consecutive slots
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_beat[0];
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_beat[1];
      end
   end

endmodule

`default_nettype wire

// ===== sv/quality_bin_run_length_encoder.sv =====
// Quality-score binning run-length encoder. Each req beat carries one raw
// quality byte and a record_end flag; each byte is binned into one of eight
// bins and runs of equal bins come out on rsp as (bin << 5) | (length - 1),
// with a run cut at 32 bytes and flushed at record end. One byte is taken
// per cycle while the queue has room: the byte is registered, then binned
// and merged into the open run, and its codes are written into a four-beat
// output queue. Each byte is held in the input register, and its codes in the
// output queue, before those codes are valid on rsp.
// A byte makes zero, one or two codes; two only when it changes bin and ends
// its record, so sustained throughput is one byte per cycle as long as the
// rsp side takes one beat per cycle, and req stalls only when the queue
// cannot hold two more beats.
`default_nettype none

module quality_bin_run_length_encoder (
   input  logic        clock,
   input  logic        reset,
   qbrle_req_if.sink   req_chan,
   qbrle_rsp_if.source rsp_chan
);
   import qbrle_pkg::*;

   // input register
   logic                    s1_valid_ff;
   logic [QualityWidth-1:0] s1_quality_ff;
   logic                    s1_record_end_ff;
   logic                    s1_advance;
   logic                    req_take;

   // run state
   bin_type       run_bin_ff, run_bin_in;
   run_count_type run_count_ff, run_count_in;
   logic          run_open_ff, run_open_in;

   // per-byte working values
   bin_type       bin;
   logic          same_bin;
   run_count_type count_inc;
   bin_type       mid_bin;
   run_count_type mid_count;
   logic          mid_open;
   logic          first_valid;
   logic [CodeWidth-1:0] first_code;
   logic          flush_valid;
   logic [CodeWidth-1:0] flush_code;

   // queue side
   logic               fifo_room;
   logic [1:0]         push_count;
   rsp_beat_type [1:0] push_beat;
   rsp_beat_type       out_beat;

   assign s1_advance     = s1_valid_ff & fifo_room;
   assign req_chan.ready = ~s1_valid_ff | s1_advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_quality_ff    <= req_chan.quality;
         s1_record_end_ff <= req_chan.record_end;
      end
   end

   // bin the byte and merge it into the open run
   always_comb begin
      bin         = bin_of(s1_quality_ff);
      same_bin    = run_open_ff & (bin == run_bin_ff);
      count_inc   = run_count_ff + CountWidth'(1);
      mid_bin     = run_bin_ff;
      mid_count   = run_count_ff;
      mid_open    = run_open_ff;
      first_valid = 1'b0;
      first_code  = {run_bin_ff, run_count_ff};

      if (same_bin) begin
         if (count_inc == RunCountMax) begin
            // run of 32: emit and close
            first_valid = 1'b1;
            first_code  = {run_bin_ff, RunCountMax};
            mid_open    = 1'b0;
            mid_count   = '0;
         end else begin
            mid_count = count_inc;
         end
      end else begin
         // bin change: close the old run, open a new one
         first_valid = run_open_ff;
         mid_bin     = bin;
         mid_count   = '0;
         mid_open    = 1'b1;
      end

      // flush whatever is open at record end
      flush_valid = s1_record_end_ff & mid_open;
      flush_code  = {mid_bin, mid_count};

      run_bin_in = mid_bin;
      if (s1_record_end_ff) begin
         run_open_in  = 1'b0;
         run_count_in = '0;
      end else begin
         run_open_in  = mid_open;
         run_count_in = mid_count;
      end
   end

   // build the beats for the queue
   always_comb begin
      push_beat[0].code         = first_valid ? first_code : flush_code;
      push_beat[0].record_done  = s1_record_end_ff & ~(first_valid & flush_valid);
      push_beat[0].last_of_item = ~(first_valid & flush_valid);
      push_beat[1].code         = flush_code;
      push_beat[1].record_done  = 1'b1;
      push_beat[1].last_of_item = 1'b1;

      if (s1_advance) begin
         push_count = 2'(first_valid) + 2'(flush_valid);
      end else begin
         push_count = 2'd0;
      end
   end

   // advance the run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_bin_ff   <= '0;
         run_count_ff <= '0;
         run_open_ff  <= 1'b0;
      end else if (s1_advance) begin
         run_bin_ff   <= run_bin_in;
         run_count_ff <= run_count_in;
         run_open_ff  <= run_open_in;
      end
   end

   qbrle_beat_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_beat  (push_beat),
      .room       (fifo_room),
      .out_valid  (rsp_chan.valid),
      .out_beat   (out_beat),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.code         = out_beat.code;
   assign rsp_chan.record_done  = out_beat.record_done;
   assign rsp_chan.last_of_item = out_beat.last_of_item;

endmodule

`default_nettype wire

// ===== sv/qbrle_checker.sv =====
`default_nettype none

module qbrle_port_assertions (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [qbrle_pkg::CodeWidth-1:0] rsp_code,
   input logic                             rsp_record_done,
   input logic                             rsp_last_of_item
);

   // a stalled code beat holds
   hold_stalled_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code)
         && $stable(rsp_record_done) && $stable(rsp_last_of_item))
      else $error("rsp beat changed while stalled");

   // nothing on rsp right after reset
   idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // the record's final code is always the last one of its byte
   done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_done |-> rsp_last_of_item)
      else $error("record_done without last_of_item");

   // the second code of a pair is already queued
   pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> rsp_valid && rsp_last_of_item)
      else $error("second code of a pair missing");

endmodule

bind quality_bin_run_length_encoder qbrle_port_assertions u_qbrle_port_assertions (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_code         (rsp_chan.code),
   .rsp_record_done  (rsp_chan.record_done),
   .rsp_last_of_item (rsp_chan.last_of_item)
);

`default_nettype wire

// ===== tb/qbrle_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

module qbrle_checker
   import qbrle_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [QualityWidth-1:0] req_quality,
   input  logic                    req_record_end,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [CodeWidth-1:0]    rsp_code,
   input  logic                    rsp_record_done,
   input  logic                    rsp_last_of_item,
   output int unsigned             mismatches,
   output int unsigned             codes_pending,
   output int unsigned             codes_checked,
   output int unsigned             records_closed,
   output int unsigned             full_runs
);

   // predicted run state
   bin_type       open_bin;
   run_count_type open_len;
   logic          run_is_open;

   // codes predicted but not yet seen on the result channel
   rsp_beat_type  expected_codes[$];

   // count the floors a byte clears; that count is its bin
   function automatic bin_type quality_bin(input logic [QualityWidth-1:0] q);
      logic [QualityWidth-1:0] floors [7];
      bin_type                 b;
      floors = '{Bin1Floor, Bin2Floor, Bin3Floor, Bin4Floor,
                 Bin5Floor, Bin6Floor, Bin7Floor};
      b = '0;
      for (int i = 0; i < 7; i++) begin
         if (q >= floors[i]) b = bin_type'(i + 1);
      end
      return b;
   endfunction

   // merge one byte into the open run and queue the codes it releases
   task automatic take_quality(input logic [QualityWidth-1:0] q, input logic last);
      bin_type      b;
      rsp_beat_type beats [2];
      int           n;
      b = quality_bin(q);
      n = 0;
      if (run_is_open && b == open_bin) begin
         open_len = open_len + 1'b1;
         // full run of 32: emit now and close
         if (open_len == RunCountMax) begin
            beats[n] = '{code: {open_bin, open_len}, record_done: 1'b0, last_of_item: 1'b0};
            n++;
            run_is_open = 1'b0;
            open_len    = '0;
         end
      end else begin
         // bin change: flush the old run before opening the new one
         if (run_is_open) begin
            beats[n] = '{code: {open_bin, open_len}, record_done: 1'b0, last_of_item: 1'b0};
            n++;
         end
         open_bin    = b;
         open_len    = '0;
         run_is_open = 1'b1;
      end
      // record end: flush whatever is open, flag the final code
      if (last) begin
         if (run_is_open) begin
            beats[n] = '{code: {open_bin, open_len}, record_done: 1'b0, last_of_item: 1'b0};
            n++;
            run_is_open = 1'b0;
            open_len    = '0;
         end
         if (n > 0) beats[n-1].record_done = 1'b1;
      end
      if (n > 0) beats[n-1].last_of_item = 1'b1;
      for (int i = 0; i < n; i++) expected_codes.push_back(beats[i]);
   endtask

   // compare one code beat with the oldest prediction
   task automatic check_code();
      rsp_beat_type want;
      if (expected_codes.size() == 0) begin
         $display("%0t: unexpected code beat: code %02h record_done %0b last_of_item %0b",
                  $time, rsp_code, rsp_record_done, rsp_last_of_item);
         mismatches++;
         return;
      end
      want = expected_codes.pop_front();
      codes_checked++;
      if (rsp_code != want.code) begin
         $display("%0t: code mismatch: expected %02h, got %02h", $time, want.code, rsp_code);
         mismatches++;
      end
      if (rsp_record_done != want.record_done) begin
         $display("%0t: record_done mismatch on code %02h: expected %0b, got %0b",
                  $time, want.code, want.record_done, rsp_record_done);
         mismatches++;
      end
      if (rsp_last_of_item != want.last_of_item) begin
         $display("%0t: last_of_item mismatch on code %02h: expected %0b, got %0b",
                  $time, want.code, want.last_of_item, rsp_last_of_item);
         mismatches++;
      end
      if (want.record_done) records_closed++;
      if (want.code[CountWidth-1:0] == RunCountMax) full_runs++;
   endtask

   // check results first, then predict from the byte taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         open_bin       = '0;
         open_len       = '0;
         run_is_open    = 1'b0;
         expected_codes.delete();
         mismatches     = 0;
         codes_checked  = 0;
         records_closed = 0;
         full_runs      = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_code();
         if (req_valid && req_ready) take_quality(req_quality, req_record_end);
      end
      codes_pending = expected_codes.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_quality_bin_run_length_encoder.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_quality_bin_run_length_encoder;
   import qbrle_pkg::*;

   localparam int unsigned ByteTarget = 1350;
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainCycles = 8;

   logic clock;
   logic reset;

   qbrle_req_if req_chan ();
   qbrle_rsp_if rsp_chan ();

   logic        req_took;
   logic        rsp_took;
   logic        req_burst;
   logic        rsp_burst;
   int unsigned bytes_sent;
   int unsigned cycle_count;

   int unsigned mismatches;
   int unsigned codes_pending;
   int unsigned codes_checked;
   int unsigned records_closed;
   int unsigned full_runs;

   quality_bin_run_length_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   qbrle_checker code_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_quality      (req_chan.quality),
      .req_record_end   (req_chan.record_end),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_code         (rsp_chan.code),
      .rsp_record_done  (rsp_chan.record_done),
      .rsp_last_of_item (rsp_chan.last_of_item),
      .mismatches       (mismatches),
      .codes_pending    (codes_pending),
      .codes_checked    (codes_checked),
      .records_closed   (records_closed),
      .full_runs        (full_runs)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // note each handshake so the drivers can see it at the falling edge
   always @(posedge clock) begin
      req_took <= req_chan.valid && req_chan.ready;
      rsp_took <= rsp_chan.valid && rsp_chan.ready;
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d codes still awaited",
                  cycle_count, codes_pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // present one byte after a random gap and hold it until taken
   task automatic send_byte(input logic [QualityWidth-1:0] q, input logic last);
      int unsigned gap;
      if ($urandom_range(39) == 0) req_burst = ~req_burst;
      gap = req_burst ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.quality    <= q;
      req_chan.record_end <= last;
      @(negedge clock);
      while (!req_took) @(negedge clock);
      bytes_sent++;
   endtask

   // a record built from runs of binned bytes, long runs cutting at 32
   task automatic send_run_record();
      logic [QualityWidth-1:0] lo [8];
      logic [QualityWidth-1:0] hi [8];
      int unsigned             run_total;
      int unsigned             run_len;
      int unsigned             b;
      lo = '{8'd0, Bin1Floor, Bin2Floor, Bin3Floor, Bin4Floor, Bin5Floor, Bin6Floor, Bin7Floor};
      hi = '{Bin1Floor - 8'd1, Bin2Floor - 8'd1, Bin3Floor - 8'd1, Bin4Floor - 8'd1,
             Bin5Floor - 8'd1, Bin6Floor - 8'd1, Bin7Floor - 8'd1, 8'd255};
      run_total = $urandom_range(6, 1);
      for (int r = 0; r < run_total; r++) begin
         b = $urandom_range(7);
         run_len = ($urandom_range(3) == 0) ? $urandom_range(36, 28) : $urandom_range(6, 1);
         for (int k = 0; k < run_len; k++) begin
            send_byte(QualityWidth'($urandom_range(hi[b], lo[b])),
                      (r == run_total - 1) && (k == run_len - 1));
         end
      end
   endtask

   // a short record of unbinned random bytes
   task automatic send_noise_record();
      int unsigned len;
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
         send_byte(QualityWidth'($urandom_range(255)), k == len - 1);
      end
   endtask

   // take code beats after random stalls
   initial begin : code_taker
      int unsigned gap;
      rsp_burst = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(39) == 0) rsp_burst = ~rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(10);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_took) @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [QualityWidth-1:0] edges [15];
      edges = '{8'd34, Bin1Floor, 8'd42, Bin2Floor, 8'd52, Bin3Floor, 8'd57, Bin4Floor,
                8'd62, Bin5Floor, 8'd67, Bin6Floor, 8'd72, Bin7Floor, 8'd255};
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.quality    = '0;
      req_chan.record_end = 1'b0;
      rsp_chan.ready      = 1'b0;
      req_took            = 1'b0;
      rsp_took            = 1'b0;
      req_burst           = 1'b0;
      bytes_sent          = 0;
      cycle_count         = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // quality zero as a one-byte record
      send_byte(8'd0, 1'b1);
      // walk every bin boundary in one record, ending on the top value
      foreach (edges[i]) send_byte(edges[i], i == 14);
      // bin change on the last byte: two codes from one byte
      send_byte(8'd80, 1'b0);
      send_byte(8'd80, 1'b0);
      send_byte(8'd40, 1'b1);
      // same bin across a record boundary must not merge
      send_byte(8'd170, 1'b1);
      send_byte(8'd85, 1'b1);

      // mostly well-formed runs, some noise
      while (bytes_sent < ByteTarget) begin
         if ($urandom_range(9) == 0) send_noise_record();
         else send_run_record();
      end
      req_chan.valid <= 1'b0;

      // drain
      while (codes_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("covered %0d bytes in %0d records: %0d codes checked, %0d full runs of 32",
               bytes_sent, records_closed, codes_checked, full_runs);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/qbrle_pkg.sv
sv/qbrle_if.sv
sv/qbrle_beat_fifo.sv
sv/quality_bin_run_length_encoder.sv
sv/qbrle_checker.sv
tb/qbrle_checker.sv
tb/tb_quality_bin_run_length_encoder.sv
